// ----- hw/rtl/psa_pkg.sv -----
// Package for the PWM-synced dual-sample averager.
// Widths, register indexes, reset values and controller/datapath structs.
// No dependencies.
package psa_pkg;

    localparam int TIME_BITS     = 16;
    localparam int SAMPLE_BITS   = 12;
    localparam int SUM_BITS      = 20;
    localparam int CYC_BITS      = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int DIV_CNT_BITS  = $clog2(SUM_BITS);

    localparam logic [CFG_IDX_BITS-1:0] REG_ON_TIME     = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PERIOD      = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_SECOND_TIME = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_DELAY = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CYCLES      = 3'd4;

    localparam logic [TIME_BITS-1:0] RST_ON_TIME     = 16'd1000;
    localparam logic [TIME_BITS-1:0] RST_PERIOD      = 16'd10000;
    localparam logic [TIME_BITS-1:0] RST_SECOND_TIME = 16'd700;
    localparam logic [TIME_BITS-1:0] RST_FIRST_DELAY = 16'd100;
    localparam logic [CYC_BITS-1:0]  RST_CYCLES      = 8'd10;

    typedef struct packed {
        logic tick;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic publish;
    } t_stat;

endpackage

// ----- hw/rtl/psa_in_if.sv -----
// Input channel of the averager: one beat per microsecond tick.
// Depends on psa_pkg.
interface psa_in_if;
    logic                               valid;
    logic                               ready;
    logic [psa_pkg::SAMPLE_BITS-1:0]    sample_mv;

    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

// ----- hw/rtl/psa_out_if.sv -----
// Output channel of the averager: one result beat per tick.
// Depends on psa_pkg.
interface psa_out_if;
    logic                               valid;
    logic                               ready;
    logic                               drive_level;
    logic                               sample_strobe;
    logic                               result_ready;
    logic [psa_pkg::SAMPLE_BITS-1:0]    first_average;
    logic [psa_pkg::SAMPLE_BITS-1:0]    second_average;

    modport source (output valid, output drive_level, output sample_strobe,
                    output result_ready, output first_average, output second_average,
                    input ready);
    modport sink   (input valid, input drive_level, input sample_strobe,
                    input result_ready, input first_average, input second_average,
                    output ready);
endinterface

// ----- hw/rtl/psa_ctrl.sv -----
// Controller of the averager: handshake, division sequencing, output valid.
// Depends on psa_pkg.
module psa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  psa_pkg::t_stat  i_stat,
    output psa_pkg::t_cmd   o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [psa_pkg::DIV_CNT_BITS-1:0] LAST_STEP =
        psa_pkg::DIV_CNT_BITS'(psa_pkg::SUM_BITS - 1);

    logic [1:0]                         r_state, n_state;
    logic [psa_pkg::DIV_CNT_BITS-1:0]   r_cnt, n_cnt;
    logic                               r_out_valid, n_out_valid;
    logic                               in_fire;

    assign o_in_ready  = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    o_cmd.tick = 1'b1;
                    if (i_stat.publish) begin
                        n_state = ST_DIV;
                        n_cnt   = '0;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_cmd.finish = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ----- hw/rtl/psa_dp.sv -----
// Datapath of the averager: config registers, period counter, accumulators,
// two bit-serial restoring dividers and the output payload register.
// Depends on psa_pkg.
module psa_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psa_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [psa_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic [psa_pkg::SAMPLE_BITS-1:0]     i_sample_mv,
    input  psa_pkg::t_cmd                       i_cmd,
    output psa_pkg::t_stat                      o_stat,
    output logic                                o_drive_level,
    output logic                                o_sample_strobe,
    output logic                                o_result_ready,
    output logic [psa_pkg::SAMPLE_BITS-1:0]     o_first_average,
    output logic [psa_pkg::SAMPLE_BITS-1:0]     o_second_average
);

    localparam int TB = psa_pkg::TIME_BITS;
    localparam int SB = psa_pkg::SAMPLE_BITS;
    localparam int UB = psa_pkg::SUM_BITS;
    localparam int CB = psa_pkg::CYC_BITS;
    localparam logic [UB-1:0] SUM_MAX = '1;
    localparam logic [UB-1:0] AVG_MAX = UB'({SB{1'b1}});

    logic [TB-1:0]  r_on_time, r_period, r_second_time, r_first_delay;
    logic [CB-1:0]  r_cycles;

    logic [TB-1:0]  r_count;
    logic [CB-1:0]  r_pd;
    logic [UB-1:0]  r_first_sum, r_second_sum;
    logic [SB-1:0]  r_first_avg, r_second_avg;

    logic [UB-1:0]  r_q1, r_q2;
    logic [CB-1:0]  r_rem1, r_rem2;
    logic [CB-1:0]  r_divisor;
    logic           r_drive_hold, r_strobe_hold;

    logic [SB-1:0]  r_o_first, r_o_second;
    logic           r_o_drive, r_o_strobe, r_o_ready;

    logic [CB-1:0]  ncyc;
    logic           drive, hit1, hit2, publish;
    logic [UB:0]    add1, add2;
    logic [UB-1:0]  n_first_sum, n_second_sum;
    logic [CB-1:0]  pd_inc;
    logic [TB:0]    next_wide;
    logic [TB-1:0]  n_count;
    logic [CB:0]    trial1, trial2;
    logic [SB-1:0]  avg1, avg2;

    assign ncyc   = (r_cycles == '0) ? CB'(1) : r_cycles;
    assign drive  = r_count < r_on_time;
    assign hit1   = r_count == r_first_delay;
    assign hit2   = r_count == r_second_time;
    assign add1   = {1'b0, r_first_sum} + (UB+1)'(i_sample_mv);
    assign add2   = {1'b0, r_second_sum} + (UB+1)'(i_sample_mv);
    assign n_first_sum  = !hit1 ? r_first_sum  : (add1[UB] ? SUM_MAX : add1[UB-1:0]);
    assign n_second_sum = !hit2 ? r_second_sum : (add2[UB] ? SUM_MAX : add2[UB-1:0]);
    assign pd_inc    = r_pd + 1'b1;
    assign publish   = hit2 && ((pd_inc == '0) || (pd_inc >= ncyc));
    assign next_wide = {1'b0, r_count} + 1'b1;
    assign n_count   = (next_wide >= {1'b0, r_period}) ? '0 : next_wide[TB-1:0];

    assign o_stat.publish = publish;

    assign trial1 = {r_rem1, r_q1[UB-1]};
    assign trial2 = {r_rem2, r_q2[UB-1]};
    assign avg1   = (r_q1 > AVG_MAX) ? '1 : r_q1[SB-1:0];
    assign avg2   = (r_q2 > AVG_MAX) ? '1 : r_q2[SB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_time     <= psa_pkg::RST_ON_TIME;
            r_period      <= psa_pkg::RST_PERIOD;
            r_second_time <= psa_pkg::RST_SECOND_TIME;
            r_first_delay <= psa_pkg::RST_FIRST_DELAY;
            r_cycles      <= psa_pkg::RST_CYCLES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                psa_pkg::REG_ON_TIME:     r_on_time     <= i_cfg_data;
                psa_pkg::REG_PERIOD:      r_period      <= i_cfg_data;
                psa_pkg::REG_SECOND_TIME: r_second_time <= i_cfg_data;
                psa_pkg::REG_FIRST_DELAY: r_first_delay <= i_cfg_data;
                psa_pkg::REG_CYCLES:      r_cycles      <= i_cfg_data[CB-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_pd         <= '0;
            r_first_sum  <= '0;
            r_second_sum <= '0;
            r_first_avg  <= '0;
            r_second_avg <= '0;
        end else if (i_cmd.tick) begin
            r_count      <= n_count;
            r_first_sum  <= n_first_sum;
            r_second_sum <= n_second_sum;
            if (hit2) begin
                r_pd <= publish ? '0 : pd_inc;
            end
        end else if (i_cmd.finish) begin
            r_first_sum  <= '0;
            r_second_sum <= '0;
            r_first_avg  <= avg1;
            r_second_avg <= avg2;
        end
    end

    // restoring division, one quotient bit per step; remainder stays below divisor
    always_ff @(posedge i_clk) begin
        if (i_cmd.tick) begin
            r_q1          <= n_first_sum;
            r_q2          <= n_second_sum;
            r_rem1        <= '0;
            r_rem2        <= '0;
            r_divisor     <= ncyc;
            r_drive_hold  <= drive;
            r_strobe_hold <= hit1 || hit2;
        end else if (i_cmd.step) begin
            if (trial1 >= {1'b0, r_divisor}) begin
                r_rem1 <= CB'(trial1 - {1'b0, r_divisor});
                r_q1   <= {r_q1[UB-2:0], 1'b1};
            end else begin
                r_rem1 <= trial1[CB-1:0];
                r_q1   <= {r_q1[UB-2:0], 1'b0};
            end
            if (trial2 >= {1'b0, r_divisor}) begin
                r_rem2 <= CB'(trial2 - {1'b0, r_divisor});
                r_q2   <= {r_q2[UB-2:0], 1'b1};
            end else begin
                r_rem2 <= trial2[CB-1:0];
                r_q2   <= {r_q2[UB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick && !publish) begin
            r_o_drive  <= drive;
            r_o_strobe <= hit1 || hit2;
            r_o_ready  <= 1'b0;
            r_o_first  <= r_first_avg;
            r_o_second <= r_second_avg;
        end else if (i_cmd.finish) begin
            r_o_drive  <= r_drive_hold;
            r_o_strobe <= r_strobe_hold;
            r_o_ready  <= 1'b1;
            r_o_first  <= avg1;
            r_o_second <= avg2;
        end
    end

    assign o_drive_level    = r_o_drive;
    assign o_sample_strobe  = r_o_strobe;
    assign o_result_ready   = r_o_ready;
    assign o_first_average  = r_o_first;
    assign o_second_average = r_o_second;

endmodule

// ----- hw/rtl/pwm_synced_dual_sample_averager_unit.sv -----
// Top level: PWM-synced dual-sample averager (controller + datapath).
// A plain tick's result beat is valid in the cycle after it is accepted; a publishing
// tick first runs 20 bit-serial divider steps and a finish state, taking no new tick.
// Throughput: one tick per cycle when nothing is published and the output is ready.
// Reset (synchronous, active low): registers to defaults, counters, sums, averages 0.
// Depends on psa_pkg, psa_in_if, psa_out_if, psa_ctrl, psa_dp.
module pwm_synced_dual_sample_averager_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psa_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [psa_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    psa_in_if.sink                              i_in,
    psa_out_if.source                           o_out
);

    psa_pkg::t_cmd  cmd;
    psa_pkg::t_stat stat;

    psa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    psa_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sample_mv      (i_in.sample_mv),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_drive_level    (o_out.drive_level),
        .o_sample_strobe  (o_out.sample_strobe),
        .o_result_ready   (o_out.result_ready),
        .o_first_average  (o_out.first_average),
        .o_second_average (o_out.second_average)
    );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for pwm_synced_dual_sample_averager_unit: drives ticks, predicts each
// result beat (drive, strobe, publish, averages) and compares field by field.
// Depends on psa_pkg, psa_in_if, psa_out_if and the unit itself.
module testbench;

    localparam int TIME_BITS     = psa_pkg::TIME_BITS;
    localparam int SAMPLE_BITS   = psa_pkg::SAMPLE_BITS;
    localparam int SUM_BITS      = psa_pkg::SUM_BITS;
    localparam int CYC_BITS      = psa_pkg::CYC_BITS;
    localparam int CFG_IDX_BITS  = psa_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = psa_pkg::CFG_DATA_BITS;

    localparam int DRAIN_CYCLES = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int RAND_PHASES  = 8;
    localparam int RAND_TICKS   = 155;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};
    localparam logic [SAMPLE_BITS-1:0] MV_MAX = {SAMPLE_BITS{1'b1}};

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic                   drive_level;
        logic                   sample_strobe;
        logic                   result_ready;
        logic [SAMPLE_BITS-1:0] first_average;
        logic [SAMPLE_BITS-1:0] second_average;
    } t_tick_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    psa_in_if  in_ch();
    psa_out_if out_ch();

    pwm_synced_dual_sample_averager_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // register mirror
    logic [TIME_BITS-1:0] cfg_on_time, cfg_period, cfg_second_time, cfg_first_delay;
    logic [CYC_BITS-1:0]  cfg_cycles;
    // predicted state
    logic [TIME_BITS-1:0]   pwm_count;
    logic [CYC_BITS-1:0]    periods_seen;
    logic [SUM_BITS-1:0]    first_acc, second_acc;
    logic [SAMPLE_BITS-1:0] first_avg, second_avg;

    logic [SAMPLE_BITS-1:0] samples_to_send[$];
    t_tick_result           tick_results_due[$];
    int ticks_queued   = 0;
    int ticks_accepted = 0;
    int beats_seen     = 0;
    int mismatch_count = 0;
    int send_idle_pct;
    int stall_pct;
    int phase_no = 0;
    logic hold_go;
    logic out_hold;

    function automatic logic [SUM_BITS-1:0] acc_add(logic [SUM_BITS-1:0] acc,
                                                    logic [SAMPLE_BITS-1:0] mv);
        logic [SUM_BITS:0] s;
        s = {1'b0, acc} + (SUM_BITS+1)'(mv);
        return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] avg_of(logic [SUM_BITS-1:0] acc,
                                                      logic [CYC_BITS-1:0] n);
        logic [SUM_BITS-1:0] q;
        q = acc / n;
        return (q > MV_MAX) ? MV_MAX : q[SAMPLE_BITS-1:0];
    endfunction

    function automatic void reset_model();
        cfg_on_time     = psa_pkg::RST_ON_TIME;
        cfg_period      = psa_pkg::RST_PERIOD;
        cfg_second_time = psa_pkg::RST_SECOND_TIME;
        cfg_first_delay = psa_pkg::RST_FIRST_DELAY;
        cfg_cycles      = psa_pkg::RST_CYCLES;
        pwm_count       = '0;
        periods_seen    = '0;
        first_acc       = '0;
        second_acc      = '0;
        first_avg       = '0;
        second_avg      = '0;
    endfunction

    // one accepted tick -> one expected result beat
    function automatic void advance_tick(logic [SAMPLE_BITS-1:0] mv);
        t_tick_result r;
        logic [CYC_BITS-1:0] ncyc;
        logic [TIME_BITS:0]  nxt;
        r = '0;
        ncyc = (cfg_cycles == '0) ? 8'd1 : cfg_cycles;
        r.drive_level = (pwm_count < cfg_on_time);
        if (pwm_count == cfg_first_delay) begin
            first_acc = acc_add(first_acc, mv);
            r.sample_strobe = 1'b1;
        end
        if (pwm_count == cfg_second_time) begin
            second_acc = acc_add(second_acc, mv);
            r.sample_strobe = 1'b1;
            periods_seen = periods_seen + 8'd1;
            if (periods_seen == '0 || periods_seen >= ncyc) begin
                first_avg    = avg_of(first_acc, ncyc);
                second_avg   = avg_of(second_acc, ncyc);
                first_acc    = '0;
                second_acc   = '0;
                periods_seen = '0;
                r.result_ready = 1'b1;
            end
        end
        nxt = {1'b0, pwm_count} + 1'b1;
        pwm_count = (nxt >= {1'b0, cfg_period}) ? '0 : nxt[TIME_BITS-1:0];
        r.first_average  = first_avg;
        r.second_average = second_avg;
        tick_results_due.push_back(r);
        ticks_accepted++;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 100)
            $display("MISMATCH @%0t beat %0d: %s", $realtime, beats_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                advance_tick(in_ch.sample_mv);
            if (!in_ch.valid || in_ch.ready) begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_ch.valid     <= 1'b1;
                    in_ch.sample_mv <= samples_to_send.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_tick_result want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (tick_results_due.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = tick_results_due.pop_front();
                    check_field("drive_level", out_ch.drive_level, want.drive_level);
                    check_field("sample_strobe", out_ch.sample_strobe, want.sample_strobe);
                    check_field("result_ready", out_ch.result_ready, want.result_ready);
                    check_field("first_average", out_ch.first_average, want.first_average);
                    check_field("second_average", out_ch.second_average,
                                want.second_average);
                end
                beats_seen++;
            end
            out_ch.ready <= !out_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    // long receiver hold-off
    initial begin
        out_hold = 1'b0;
        wait (hold_go === 1'b1);
        @(posedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        out_hold <= 1'b0;
    end

    initial begin
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic queue_sample(logic [SAMPLE_BITS-1:0] mv);
        samples_to_send.push_back(mv);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        while (ticks_accepted != ticks_queued || tick_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
    endtask

    task automatic load_config(logic [TIME_BITS-1:0] on_t, logic [TIME_BITS-1:0] per,
                               logic [TIME_BITS-1:0] t2, logic [TIME_BITS-1:0] t1,
                               logic [CYC_BITS-1:0] cyc);
        write_reg(psa_pkg::REG_ON_TIME, on_t);
        write_reg(psa_pkg::REG_PERIOD, per);
        write_reg(psa_pkg::REG_SECOND_TIME, t2);
        write_reg(psa_pkg::REG_FIRST_DELAY, t1);
        write_reg(psa_pkg::REG_CYCLES, {8'd0, cyc});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_on_time     = on_t;
        cfg_period      = per;
        cfg_second_time = t2;
        cfg_first_delay = t1;
        cfg_cycles      = cyc;
        phase_no++;
        case (t_idle_mode'(phase_no % 4))
            IDLE_NONE:     begin send_idle_pct <= 0;  stall_pct <= 0;  end
            IDLE_SENDER:   begin send_idle_pct <= 57; stall_pct <= 0;  end
            IDLE_RECEIVER: begin send_idle_pct <= 0;  stall_pct <= 57; end
            default:       begin send_idle_pct <= 27; stall_pct <= 27; end
        endcase
    endtask

    initial begin
        int per;
        logic [TIME_BITS-1:0] t1, t2;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = psa_pkg::REG_ON_TIME;
        i_cfg_data      = '0;
        in_ch.valid     = 1'b0;
        in_ch.sample_mv = '0;
        out_ch.ready    = 1'b0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        hold_go         = 1'b0;
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults
        queue_sample(12'd0);
        queue_sample(12'hFFF);
        queue_sample(12'hAAA);
        queue_sample(12'h555);
        queue_sample(12'd1);
        wait_drained();

        // both samples on one tick; count above the lowered period wraps
        load_config(16'd2, 16'd4, 16'd2, 16'd2, 8'd1);
        queue_sample(12'hFFF);
        queue_sample(12'd0);
        queue_sample(12'hFFF);
        queue_sample(12'd7);
        queue_sample(12'hFFF);
        queue_sample(12'd0);
        wait_drained();

        // zero period and zero cycle count
        load_config(16'd0, 16'd0, 16'd0, 16'd0, 8'd0);
        queue_sample(12'hFFF);
        queue_sample(12'd0);
        queue_sample(12'd2048);
        queue_sample(12'hFFF);
        wait_drained();

        // top of every range but the first delay
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 8'hFF);
        queue_sample(12'hFFF);
        queue_sample(12'h800);
        queue_sample(12'h7FF);
        wait_drained();

        // cycle count lowered below periods already done
        load_config(16'd1, 16'd3, 16'd0, 16'd1, 8'd10);
        repeat (6) queue_sample(12'hFFF);
        wait_drained();
        load_config(16'd1, 16'd3, 16'd0, 16'd1, 8'd1);
        queue_sample(12'hFFE);
        queue_sample(12'd3);
        queue_sample(12'hFFF);
        wait_drained();

        // second time unreachable: first sum saturates, then publish
        load_config(16'd1, 16'd1, 16'hFFFF, 16'd0, 8'd1);
        repeat (300) queue_sample(SAMPLE_BITS'($urandom_range(4095, 3900)));
        wait_drained();
        load_config(16'd1, 16'd1, 16'd0, 16'd0, 8'd1);
        queue_sample(12'hFFF);
        queue_sample(12'd0);
        queue_sample(12'd100);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            per = $urandom_range(16, 1);
            t2  = ($urandom_range(7) == 0) ? 16'hFFFF : TIME_BITS'($urandom_range(per - 1));
            t1  = ($urandom_range(5) == 0) ? t2 : TIME_BITS'($urandom_range(per - 1));
            load_config(TIME_BITS'($urandom_range(per + 1)), TIME_BITS'(per), t2, t1,
                        CYC_BITS'($urandom_range(4, 1)));
            if (p == 1) begin
                @(posedge i_clk);
                send_idle_pct <= 0;
                hold_go       <= 1'b1;
            end
            repeat (RAND_TICKS) begin
                case ($urandom_range(7))
                    0:       queue_sample(12'd0);
                    1:       queue_sample(12'hFFF);
                    default: queue_sample(SAMPLE_BITS'($urandom_range(4095)));
                endcase
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
